FILE: rtl/core/brse_pkg.sv
// shared types, constants and codes for the bitmap rank/select engine
`timescale 1ns / 1ps

package brse_pkg;

  localparam int TOTAL_BITS_DEF = 1024;
  localparam int WORD_BITS_DEF  = 32;

  localparam int OP_W        = 3;
  localparam int IDX_W       = 10;
  localparam int RANK_W      = 11;
  localparam int CNT_W       = 11;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // reciprocal scaling for the index split into word and bit
  localparam int RECIP_SHIFT = 20;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_FIND   = 3'd2,
    OP_SELECT = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_RD,
    ST_RMW,
    ST_SCAN,
    ST_SERIAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mod;
    logic rmw;
    logic sel_init;
    logic scan;
    logic serial;
    logic clr_start;
    logic clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic oob;
    logic sel_ok;
    logic scan_hit;
    logic scan_end;
    logic ser_hit;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/brse_ctrl.sv
// controller state machine of the bitmap rank/select engine
`timescale 1ns / 1ps

module brse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  brse_pkg::stat_t st,
  output brse_pkg::cmd_t  cmd
);

  brse_pkg::state_t state_r, state_nxt;
  logic             clr_item_r, clr_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= brse_pkg::ST_CLEAR;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_item_nxt = clr_item_r;
    cmd          = '0;
    in_tready    = 1'b0;
    unique case (state_r)
      brse_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt    = clr_item_r ? brse_pkg::ST_DONE : brse_pkg::ST_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      brse_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = brse_pkg::ST_DIV;
        end
      end
      brse_pkg::ST_DIV: begin
        unique case (st.op) inside
          brse_pkg::OP_WRITE, brse_pkg::OP_READ, brse_pkg::OP_FIND: begin
            state_nxt = brse_pkg::ST_MOD;
          end
          brse_pkg::OP_SELECT: begin
            if (st.sel_ok) begin
              cmd.sel_init = 1'b1;
              state_nxt    = brse_pkg::ST_SCAN;
            end else begin
              state_nxt = brse_pkg::ST_DONE;
            end
          end
          brse_pkg::OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            clr_item_nxt  = 1'b1;
            state_nxt     = brse_pkg::ST_CLEAR;
          end
          default: begin
            state_nxt = brse_pkg::ST_DONE;
          end
        endcase
      end
      brse_pkg::ST_MOD: begin
        cmd.mod = 1'b1;
        if (st.oob) begin
          state_nxt = brse_pkg::ST_DONE;
        end else if (st.op == brse_pkg::OP_FIND) begin
          state_nxt = brse_pkg::ST_SCAN;
        end else begin
          state_nxt = brse_pkg::ST_RD;
        end
      end
      brse_pkg::ST_RD: begin
        state_nxt = brse_pkg::ST_RMW;
      end
      brse_pkg::ST_RMW: begin
        cmd.rmw   = 1'b1;
        state_nxt = brse_pkg::ST_DONE;
      end
      brse_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_hit) begin
          state_nxt = (st.op == brse_pkg::OP_SELECT) ? brse_pkg::ST_SERIAL
                                                     : brse_pkg::ST_DONE;
        end else if (st.scan_end) begin
          state_nxt = brse_pkg::ST_DONE;
        end
      end
      brse_pkg::ST_SERIAL: begin
        cmd.serial = 1'b1;
        if (st.ser_hit) begin
          state_nxt = brse_pkg::ST_DONE;
        end
      end
      brse_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = brse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/brse_dp.sv
// datapath of the bitmap rank/select engine: word memory, scan, count, output register
`timescale 1ns / 1ps

module brse_dp #(
  parameter int TOTAL_BITS = brse_pkg::TOTAL_BITS_DEF,
  parameter int WORD_BITS  = brse_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [brse_pkg::IN_TDATA_W-1:0]  in_data,
  input  brse_pkg::cmd_t                   cmd,
  output brse_pkg::stat_t                  st,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [brse_pkg::OUT_TDATA_W-1:0] out_data
);

  localparam int WordCount = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW     = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int ScanW     = $clog2(WordCount + 1);
  localparam int BitW      = $clog2(WORD_BITS);
  localparam int PosW      = $clog2(WordCount * WORD_BITS + 1);
  localparam int CntW      = $clog2(TOTAL_BITS + 1);
  localparam int Recip     = (1 << brse_pkg::RECIP_SHIFT) / WORD_BITS;
  localparam int ProdW     = brse_pkg::IDX_W + brse_pkg::RECIP_SHIFT + 1;
  localparam int IdxW      = brse_pkg::IDX_W;

  logic [WORD_BITS-1:0] mem [WordCount];
  logic [WORD_BITS-1:0] rdata_r;

  brse_pkg::op_t             op_r;
  logic [IdxW-1:0]           idx_r;
  logic                      val_r;
  logic [brse_pkg::RANK_W-1:0] rank_r;
  logic [IdxW-1:0]           qest_r;
  logic [AddrW-1:0]          word_r;
  logic [BitW-1:0]           bit_r;
  logic [ScanW-1:0]          scan_addr_r;
  logic [PosW-1:0]           scan_base_r;
  logic                      scan_first_r;
  logic                      rvld_r;
  logic [PosW-1:0]           rbase_r;
  logic                      rfirst_r;
  logic                      rlast_r;
  logic [CntW-1:0]           remain_r;
  logic [WORD_BITS-1:0]      shift_r;
  logic [PosW-1:0]           shift_pos_r;
  logic [CntW-1:0]           count_r;
  logic                      res_bit_r;
  logic                      res_found_r;
  logic [PosW-1:0]           res_index_r;
  logic                      out_vld_r;
  logic [brse_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [AddrW-1:0]          clr_addr_r;

  logic [ProdW-1:0]     prod;
  logic [IdxW-1:0]      qw;
  logic [IdxW-1:0]      rem;
  logic                 rem_ge;
  logic [IdxW-1:0]      word_q;
  logic [IdxW-1:0]      bit_q;
  logic [IdxW-1:0]      base_q;
  logic                 oob;
  logic [AddrW-1:0]     rd_addr;
  logic [WORD_BITS-1:0] first_mask;
  logic [WORD_BITS-1:0] masked;
  logic [BitW-1:0]      enc;
  logic [CntW-1:0]      pc;
  logic                 is_sel;
  logic                 scan_hit;
  logic                 ser_hit;
  logic                 old_bit;
  logic [WORD_BITS-1:0] wword;
  logic                 bit_change;
  logic                 clr_last;

  // index split into word and bit by reciprocal multiply and one correction
  assign prod   = ProdW'(idx_r) * ProdW'(Recip);
  assign qw     = IdxW'(qest_r * IdxW'(WORD_BITS));
  assign rem    = idx_r - qw;
  assign rem_ge = rem >= IdxW'(WORD_BITS);
  assign word_q = rem_ge ? qest_r + 1'b1 : qest_r;
  assign bit_q  = rem_ge ? rem - IdxW'(WORD_BITS) : rem;
  assign base_q = idx_r - bit_q;
  assign oob    = 32'(idx_r) >= 32'(TOTAL_BITS);

  assign rd_addr = cmd.scan ? AddrW'(scan_addr_r) : word_r;

  always_comb begin
    pc  = '0;
    enc = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      first_mask[i] = !rfirst_r || (BitW'(i) >= bit_r);
      pc = pc + CntW'(rdata_r[i]);
    end
    masked = rdata_r & first_mask;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) enc = BitW'(i);
    end
  end

  assign is_sel     = (op_r == brse_pkg::OP_SELECT);
  assign scan_hit   = rvld_r && (is_sel ? (remain_r <= pc) : (masked != '0));
  assign ser_hit    = shift_r[0] && (remain_r == CntW'(1));
  assign old_bit    = rdata_r[bit_r];
  assign bit_change = cmd.rmw && (op_r == brse_pkg::OP_WRITE) && (old_bit != val_r);
  assign clr_last   = clr_addr_r == AddrW'(WordCount - 1);

  always_comb begin
    wword        = rdata_r;
    wword[bit_r] = val_r;
  end

  always_comb begin
    st.op       = op_r;
    st.oob      = oob;
    st.sel_ok   = (rank_r != '0) && (32'(rank_r) <= 32'(count_r));
    st.scan_hit = scan_hit;
    st.scan_end = rvld_r && rlast_r && !scan_hit;
    st.ser_hit  = ser_hit;
    st.clr_last = clr_last;
    st.out_free = !out_vld_r || out_tready;
  end

  // word memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr_r] <= '0;
    end else if (bit_change) begin
      mem[word_r] <= wword;
    end
    rdata_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rvld_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr && clr_last) begin
        count_r <= '0;
      end else if (bit_change) begin
        count_r <= val_r ? count_r + 1'b1 : count_r - 1'b1;
      end
      rvld_r <= cmd.scan && (32'(scan_addr_r) < WordCount);
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.clr_start) begin
        clr_addr_r <= '0;
      end else if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // item, scan and result payload
  always_ff @(posedge clk) begin
    qest_r   <= prod[brse_pkg::RECIP_SHIFT +: IdxW];
    rbase_r  <= scan_base_r;
    rfirst_r <= scan_first_r;
    rlast_r  <= 32'(scan_addr_r) == WordCount - 1;

    if (cmd.load) begin
      op_r        <= brse_pkg::op_t'(in_data[2:0]);
      idx_r       <= in_data[12:3];
      val_r       <= in_data[13];
      rank_r      <= in_data[24:14];
      res_bit_r   <= 1'b0;
      res_found_r <= 1'b0;
      res_index_r <= '0;
    end

    if (cmd.mod) begin
      word_r       <= AddrW'(word_q);
      bit_r        <= BitW'(bit_q);
      scan_addr_r  <= ScanW'(word_q);
      scan_base_r  <= PosW'(base_q);
      scan_first_r <= 1'b1;
    end else if (cmd.sel_init) begin
      scan_addr_r  <= '0;
      scan_base_r  <= '0;
      scan_first_r <= 1'b0;
    end else if (cmd.scan) begin
      scan_addr_r  <= scan_addr_r + 1'b1;
      scan_base_r  <= scan_base_r + PosW'(WORD_BITS);
      scan_first_r <= 1'b0;
    end

    if (cmd.sel_init) begin
      remain_r <= CntW'(rank_r);
    end else if (cmd.scan && is_sel && rvld_r && !scan_hit) begin
      remain_r <= remain_r - pc;
    end else if (cmd.serial && shift_r[0]) begin
      remain_r <= remain_r - 1'b1;
    end

    if (cmd.scan && scan_hit && is_sel) begin
      shift_r     <= rdata_r;
      shift_pos_r <= rbase_r;
    end else if (cmd.serial) begin
      shift_r     <= shift_r >> 1;
      shift_pos_r <= shift_pos_r + 1'b1;
    end

    if (cmd.rmw && (op_r == brse_pkg::OP_READ)) begin
      res_bit_r <= old_bit;
    end
    if (cmd.scan && scan_hit && !is_sel) begin
      res_found_r <= 1'b1;
      res_index_r <= rbase_r + PosW'(enc);
    end else if (cmd.serial && ser_hit) begin
      res_found_r <= 1'b1;
      res_index_r <= shift_pos_r;
    end

    if (cmd.emit) begin
      out_data_r <= {1'b0, brse_pkg::CNT_W'(count_r), IdxW'(res_index_r),
                     res_found_r, res_bit_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_data   = out_data_r;

endmodule

FILE: rtl/core/bitmap_rank_select_engine.sv
// top level of the bitmap rank/select engine
//
// input beats on in_t*: one operation per beat (write, read, find-next, select, clear).
// result beats on out_t*: exactly one per input beat, in order, each with the set count.
// one item is in work at a time; the next beat is taken once the result is
// parked in the output register, even while that register still waits.
// steps from accept to out_tvalid, by operation:
//   write, read: index split, word read, read-modify-write, result
//   find-next:   index split, then one memory word read per cycle to a hit or the end
//   select:      rank check, word scan by popcount then
//                a bit-serial walk through the located word
//   clear-all:   one word zeroed per cycle over the whole memory
//   others:      straight to the result
// the one-read-per-cycle word memory and the scan loop over it set the pace of find-next and select
// reset: rst_n low clears the count, then a sweep zeroes the memory
// with in_tready low; a held-off receiver stalls the block in its final step
`timescale 1ns / 1ps

module bitmap_rank_select_engine #(
  parameter int TOTAL_BITS = brse_pkg::TOTAL_BITS_DEF,
  parameter int WORD_BITS  = brse_pkg::WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // operation[2:0], bit_index[12:3], bit_value[13], rank[24:14], zero fill
  input  logic [brse_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // bit_out[0], found[1], found_index[11:2], total_set[22:12], zero fill
  output logic [brse_pkg::OUT_TDATA_W-1:0] out_tdata
);

  brse_pkg::cmd_t  cmd;
  brse_pkg::stat_t st;

  brse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  brse_dp #(
    .TOTAL_BITS (TOTAL_BITS),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata)
  );

endmodule

FILE: rtl/core/brse_checker.sv
// port-level checks for the bitmap rank/select engine, bound to the top level
`timescale 1ns / 1ps

module brse_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [brse_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [brse_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // memory sweep follows reset, no beat taken
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken straight after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  // no position without a hit, and no read bit together with a hit
  a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1] || out_tdata[11:2] == 10'd0) &&
                   !(out_tdata[0] && out_tdata[1]))
    else $error("inconsistent result fields");

endmodule

bind bitmap_rank_select_engine brse_checker u_brse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/tb.sv
// testbench for the bitmap rank/select engine: directed and random operations
`timescale 1ns / 1ps

module tb;

  localparam int MAP_BITS  = 1024;
  localparam int CYCLE_CAP = 400000;

  typedef struct {
    logic        bit_out;
    logic        found;
    logic [9:0]  found_index;
    logic [10:0] total_set;
  } lookup_t;

  class bitmap_scoreboard;
    bit [MAP_BITS-1:0] bits;
    int unsigned       ones;
    lookup_t           awaited_q[$];
    int unsigned       accepted;
    int unsigned       errors;

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      errors++;
    endtask

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    // updates the bitmap copy and queues the lookup this beat should produce
    function void note_input(logic [2:0] op, logic [9:0] idx, logic val, logic [10:0] rank);
      lookup_t     res;
      int unsigned seen;
      res = '{1'b0, 1'b0, 10'd0, 11'd0};
      accepted++;
      case (op)
        brse_pkg::OP_WRITE: begin
          if (val && !bits[idx]) begin
            bits[idx] = 1'b1;
            ones++;
          end else if (!val && bits[idx]) begin
            bits[idx] = 1'b0;
            ones--;
          end
        end
        brse_pkg::OP_READ: res.bit_out = bits[idx];
        brse_pkg::OP_FIND: begin
          for (int p = idx; p < MAP_BITS; p++) begin
            if (bits[p]) begin
              res.found = 1'b1;
              res.found_index = p[9:0];
              break;
            end
          end
        end
        brse_pkg::OP_SELECT: begin
          if (rank != 0 && rank <= ones) begin
            seen = 0;
            for (int p = 0; p < MAP_BITS; p++) begin
              if (bits[p]) begin
                seen++;
                if (seen == rank) begin
                  res.found = 1'b1;
                  res.found_index = p[9:0];
                  break;
                end
              end
            end
          end
        end
        brse_pkg::OP_CLEAR: begin
          bits = '0;
          ones = 0;
        end
        default: ;
      endcase
      res.total_set = ones[10:0];
      awaited_q.push_back(res);
    endfunction

    task check_result(logic [brse_pkg::OUT_TDATA_W-1:0] d);
      lookup_t want;
      if (awaited_q.size() == 0) begin
        report("result beat with nothing pending", int'(d), 0);
      end else begin
        want = awaited_q.pop_front();
        if (d[0] !== want.bit_out) report("bit_out", d[0], want.bit_out);
        if (d[1] !== want.found) report("found", d[1], want.found);
        if (d[11:2] !== want.found_index) report("found_index", d[11:2], want.found_index);
        if (d[22:12] !== want.total_set) report("total_set", d[22:12], want.total_set);
        if (d[23] !== 1'b0) report("zero fill", d[23], 0);
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [brse_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [brse_pkg::OUT_TDATA_W-1:0] out_tdata;

  bitmap_scoreboard sb;
  int unsigned      cycles     = 0;
  int unsigned      burst_left = 0;
  logic [9:0]       window     = '0;

  bitmap_rank_select_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver: random stall pattern, with one long hold-off once traffic is flowing
  initial begin : result_sink
    int unsigned mode, run;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sb.accepted >= 120) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [9:0] idx, input logic val,
                         input logic [10:0] rank);
    int unsigned gap;
    in_tdata  <= {7'd0, rank, val, idx, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, idx, val, rank);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_op();
    int unsigned      r;
    logic [2:0]       op;
    logic [9:0]       idx;
    logic             val;
    logic [10:0]      rank;
    r = $urandom_range(0, 99);
    if (r < 38)      op = brse_pkg::OP_WRITE;
    else if (r < 52) op = brse_pkg::OP_READ;
    else if (r < 70) op = brse_pkg::OP_FIND;
    else if (r < 93) op = brse_pkg::OP_SELECT;
    else if (r < 96) op = brse_pkg::OP_CLEAR;
    else             op = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 1)) idx = 10'($urandom_range(0, MAP_BITS - 1));
    else                      idx = window + 10'($urandom_range(0, 47));
    val = ($urandom_range(0, 9) < 7);
    r = $urandom_range(0, 9);
    if (r < 7)       rank = 11'($urandom_range(1, sb.ones + 2));
    else if (r == 7) rank = '0;
    else if (r == 8) rank = sb.ones[10:0];
    else             rank = 11'($urandom_range(0, 2047));
    send_op(op, idx, val, rank);
  endtask

  initial begin : stimulus
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty bitmap lookups
    send_op(brse_pkg::OP_READ,   10'd0,    1'b0, 11'd0);
    send_op(brse_pkg::OP_FIND,   10'd0,    1'b0, 11'd0);
    send_op(brse_pkg::OP_SELECT, 10'd0,    1'b0, 11'd1);
    // end positions, repeated set leaves the count alone
    send_op(brse_pkg::OP_WRITE,  10'd0,    1'b1, 11'd0);
    send_op(brse_pkg::OP_WRITE,  10'd1023, 1'b1, 11'd2047);
    send_op(brse_pkg::OP_WRITE,  10'd1023, 1'b1, 11'd0);
    send_op(brse_pkg::OP_READ,   10'd1023, 1'b0, 11'd0);
    send_op(brse_pkg::OP_FIND,   10'd1,    1'b0, 11'd0);
    send_op(brse_pkg::OP_FIND,   10'd1023, 1'b0, 11'd0);
    send_op(brse_pkg::OP_SELECT, 10'd0,    1'b0, 11'd1);
    send_op(brse_pkg::OP_SELECT, 10'd0,    1'b0, 11'd2);
    send_op(brse_pkg::OP_SELECT, 10'd0,    1'b0, 11'd3);
    send_op(brse_pkg::OP_SELECT, 10'd0,    1'b0, 11'd0);
    send_op(brse_pkg::OP_SELECT, 10'd1023, 1'b1, 11'd2047);
    // word boundaries and clearing an already clear bit
    send_op(brse_pkg::OP_WRITE,  10'd31,   1'b1, 11'd0);
    send_op(brse_pkg::OP_WRITE,  10'd32,   1'b1, 11'd0);
    send_op(brse_pkg::OP_WRITE,  10'd0,    1'b0, 11'd0);
    send_op(brse_pkg::OP_WRITE,  10'd0,    1'b0, 11'd0);
    send_op(brse_pkg::OP_FIND,   10'd0,    1'b0, 11'd0);
    send_op(brse_pkg::OP_SELECT, 10'd0,    1'b0, 11'd2);
    // undefined operation codes leave the state alone
    send_op(3'd5, 10'd512, 1'b1, 11'd1);
    send_op(3'd6, 10'd3,   1'b1, 11'd1024);
    send_op(3'd7, 10'd1023, 1'b1, 11'd2047);
    send_op(brse_pkg::OP_CLEAR,  10'd1023, 1'b1, 11'd2047);
    send_op(brse_pkg::OP_FIND,   10'd0,    1'b0, 11'd0);

    for (int i = 0; i < 550; i++) begin
      if (i % 40 == 0) window = 10'($urandom_range(0, MAP_BITS - 1));
      if (i == 300) wait_drained();
      random_op();
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still pending", sb.pending(), 0);
    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/brse_pkg.sv
rtl/core/brse_ctrl.sv
rtl/core/brse_dp.sv
rtl/core/bitmap_rank_select_engine.sv
rtl/core/brse_checker.sv
sim/tb.sv
